### hdl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`default_nettype none
package jsu_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_SOLIDUS   = 8'h2F;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CTRL_MAX     = 8'h1F;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR    = 2'd1;
   localparam logic [1:0] ST_BAD_UNICODE = 2'd2;

   typedef enum logic [2:0] {
      MODE_TEXT = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_HEX1 = 3'd2,
      MODE_HEX2 = 3'd3,
      MODE_HEX3 = 3'd4,
      MODE_HEX4 = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       last;
      logic       is_backslash;
      logic       is_forbidden;
      logic       esc_ok;
      logic [7:0] esc_byte;
      logic       is_u;
      logic       hex_ok;
      logic [3:0] hex_digit;
   } item_type;

   typedef struct packed {
      logic       out_valid;
      logic [7:0] out_byte;
      logic [1:0] status;
      logic       out_last;
   } rsp_type;

endpackage
`default_nettype wire

### hdl/jsu_front.sv
// Front end: classifies each raw byte for the escape decoder.
`default_nettype none
module jsu_front (
   input  wire logic [7:0]        in_byte,
   input  wire logic              in_last,
   output jsu_pkg::item_type      item
);

   always_comb begin
      item              = '0;
      item.raw_byte     = in_byte;
      item.last         = in_last;
      item.is_backslash = (in_byte == jsu_pkg::CH_BACKSLASH);
      item.is_forbidden = (in_byte == jsu_pkg::CH_QUOTE) || (in_byte <= jsu_pkg::CTRL_MAX);
      item.is_u         = (in_byte == 8'h75);

      unique case (in_byte)
         jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SOLIDUS: begin
            item.esc_ok   = 1'b1;
            item.esc_byte = in_byte;
         end
         8'h62: begin
            item.esc_ok   = 1'b1;
            item.esc_byte = 8'h08;
         end
         8'h66: begin
            item.esc_ok   = 1'b1;
            item.esc_byte = 8'h0C;
         end
         8'h6E: begin
            item.esc_ok   = 1'b1;
            item.esc_byte = 8'h0A;
         end
         8'h72: begin
            item.esc_ok   = 1'b1;
            item.esc_byte = 8'h0D;
         end
         8'h74: begin
            item.esc_ok   = 1'b1;
            item.esc_byte = 8'h09;
         end
         default: begin
            item.esc_ok   = 1'b0;
            item.esc_byte = 8'h00;
         end
      endcase

      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         item.hex_ok    = 1'b1;
         item.hex_digit = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         item.hex_ok    = 1'b1;
         item.hex_digit = in_byte[3:0] + 4'd9;
      end else begin
         item.hex_ok    = 1'b0;
         item.hex_digit = 4'd0;
      end
   end

endmodule
`default_nettype wire

### hdl/jsu_queue.sv
// Short queue of classified items between the front end and the decoder.
`default_nettype none
module jsu_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  jsu_pkg::item_type      push_item,
   output logic                   full,
   input  wire logic              pop,
   output jsu_pkg::item_type      pop_item,
   output logic                   empty
);

   jsu_pkg::item_type                     entry_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [jsu_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [jsu_pkg::QUEUE_CNT_W-1:0]       count_ff, count_in;
   logic                                  wr_en, rd_en;

   assign full     = (count_ff == jsu_pkg::QUEUE_CNT_W'(jsu_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign wr_en    = push && !full;
   assign rd_en    = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### hdl/jsu_back.sv
// Back end: escape state machine and result queue.
`default_nettype none
module jsu_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  jsu_pkg::item_type      item,
   input  wire logic              item_empty,
   output logic                   item_pop,
   output jsu_pkg::rsp_type       rsp,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop
);

   jsu_pkg::mode_type                  mode_ff, mode_in;
   logic [7:0]                         hex_ff, hex_in;
   logic [1:0]                         err_ff, err_in;
   logic [1:0]                         status;
   logic [7:0]                         hex_shift;
   logic                               fire;
   logic                               dec_valid;
   logic [7:0]                         dec_byte;
   jsu_pkg::rsp_type                   result;

   jsu_pkg::rsp_type                   out_ff [jsu_pkg::QUEUE_DEPTH];
   logic [jsu_pkg::QUEUE_PTR_W-1:0]    owr_ff, owr_in, ord_ff, ord_in;
   logic [jsu_pkg::QUEUE_CNT_W-1:0]    ocnt_ff, ocnt_in;
   logic                               out_full, out_rd;

   assign out_full  = (ocnt_ff == jsu_pkg::QUEUE_CNT_W'(jsu_pkg::QUEUE_DEPTH));
   assign rsp_empty = (ocnt_ff == '0);
   assign out_rd    = rsp_pop && !rsp_empty;
   assign fire      = !item_empty && !out_full;
   assign item_pop  = fire;
   assign hex_shift = {hex_ff[3:0], item.hex_digit};
   assign rsp       = out_ff[ord_ff];

   // Next mode, partial hex value and sticky status after the current byte.
   always_comb begin
      mode_in = mode_ff;
      hex_in  = hex_ff;
      status  = err_ff;
      unique case (mode_ff)
         jsu_pkg::MODE_TEXT: begin
            if (item.is_backslash) begin
               if (item.last) begin
                  if (err_ff == jsu_pkg::ST_OK) status = jsu_pkg::ST_BAD_CHAR;
               end else begin
                  mode_in = jsu_pkg::MODE_ESC;
               end
            end else if (item.is_forbidden) begin
               if (err_ff == jsu_pkg::ST_OK) status = jsu_pkg::ST_BAD_CHAR;
            end
         end
         jsu_pkg::MODE_ESC: begin
            mode_in = jsu_pkg::MODE_TEXT;
            if (item.esc_ok) begin
               mode_in = jsu_pkg::MODE_TEXT;
            end else if (item.is_u) begin
               if (item.last) begin
                  if (err_ff == jsu_pkg::ST_OK) status = jsu_pkg::ST_BAD_UNICODE;
               end else begin
                  mode_in = jsu_pkg::MODE_HEX1;
                  hex_in  = 8'h00;
               end
            end else begin
               if (err_ff == jsu_pkg::ST_OK) status = jsu_pkg::ST_BAD_CHAR;
            end
         end
         jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2, jsu_pkg::MODE_HEX3,
         jsu_pkg::MODE_HEX4: begin
            if (!item.hex_ok) begin
               if (err_ff == jsu_pkg::ST_OK) status = jsu_pkg::ST_BAD_UNICODE;
               mode_in = jsu_pkg::MODE_TEXT;
               hex_in  = 8'h00;
            end else if (mode_ff == jsu_pkg::MODE_HEX4) begin
               mode_in = jsu_pkg::MODE_TEXT;
               hex_in  = 8'h00;
            end else begin
               hex_in = hex_shift;
               if (item.last) begin
                  if (err_ff == jsu_pkg::ST_OK) status = jsu_pkg::ST_BAD_UNICODE;
               end else begin
                  unique case (mode_ff)
                     jsu_pkg::MODE_HEX1: mode_in = jsu_pkg::MODE_HEX2;
                     jsu_pkg::MODE_HEX2: mode_in = jsu_pkg::MODE_HEX3;
                     default:            mode_in = jsu_pkg::MODE_HEX4;
                  endcase
               end
            end
         end
         default: begin
            mode_in = jsu_pkg::MODE_TEXT;
            hex_in  = 8'h00;
         end
      endcase
      err_in = status;
      if (item.last) begin
         mode_in = jsu_pkg::MODE_TEXT;
         hex_in  = 8'h00;
         err_in  = jsu_pkg::ST_OK;
      end
   end

   // Decoded byte for the current input byte.
   always_comb begin
      dec_valid = 1'b0;
      dec_byte  = 8'h00;
      unique case (mode_ff)
         jsu_pkg::MODE_TEXT: begin
            if (!item.is_backslash && !item.is_forbidden) begin
               dec_valid = 1'b1;
               dec_byte  = item.raw_byte;
            end
         end
         jsu_pkg::MODE_ESC: begin
            if (item.esc_ok) begin
               dec_valid = 1'b1;
               dec_byte  = item.esc_byte;
            end
         end
         jsu_pkg::MODE_HEX4: begin
            if (item.hex_ok) begin
               dec_valid = 1'b1;
               dec_byte  = hex_shift;
            end
         end
         default: begin
            dec_valid = 1'b0;
            dec_byte  = 8'h00;
         end
      endcase
      result.out_valid = dec_valid;
      result.out_byte  = dec_byte;
      result.status    = status;
      result.out_last  = item.last;
   end

   always_comb begin
      owr_in  = fire ? owr_ff + 1'b1 : owr_ff;
      ord_in  = out_rd ? ord_ff + 1'b1 : ord_ff;
      ocnt_in = ocnt_ff;
      if (fire && !out_rd) begin
         ocnt_in = ocnt_ff + 1'b1;
      end else if (out_rd && !fire) begin
         ocnt_in = ocnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= jsu_pkg::MODE_TEXT;
         hex_ff  <= 8'h00;
         err_ff  <= jsu_pkg::ST_OK;
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (fire) begin
            mode_ff <= mode_in;
            hex_ff  <= hex_in;
            err_ff  <= err_in;
         end
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff[owr_ff] <= result;
      end
   end

endmodule
`default_nettype wire

### hdl/json_string_unescaper_core.sv
// Top level of the JSON string unescaper.
// The block takes the bytes of a JSON string body, one per transfer, and
// returns exactly one result per byte in the same order: a decoded byte with
// its valid flag, the sticky error status and a copy of the last flag. It
// sustains one byte per clock cycle when neither side stalls. A byte is
// classified as it enters a two-entry queue, and the escape state machine
// decodes the oldest queued byte in the same cycle into a two-entry result
// queue. A result passes the input queue and then the result queue on its
// way out. Both queues let the input and result sides stall independently.
`default_nettype none
module json_string_unescaper_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            empty,
   input  wire logic       pop,
   output logic            rsp_out_valid,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_status,
   output logic            rsp_out_last
);

   jsu_pkg::item_type  front_item;
   jsu_pkg::item_type  queue_item;
   jsu_pkg::rsp_type   rsp;
   logic               queue_empty;
   logic               queue_pop;

   jsu_front u_front (
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .item    (front_item)
   );

   jsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (queue_item),
      .item_empty (queue_empty),
      .item_pop   (queue_pop),
      .rsp        (rsp),
      .rsp_empty  (empty),
      .rsp_pop    (pop)
   );

   assign rsp_out_valid = rsp.out_valid;
   assign rsp_out_byte  = rsp.out_byte;
   assign rsp_status    = rsp.status;
   assign rsp_out_last  = rsp.out_last;

endmodule
`default_nettype wire
